// ===== rtl/sorted_group_aggregator_core_defines.svh =====
// Assertion helpers for the RTL (used by sga_back)
`ifndef SORTED_GROUP_AGGREGATOR_CORE_DEFINES_SVH
`define SORTED_GROUP_AGGREGATOR_CORE_DEFINES_SVH

`define SGA_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sga assertion failed");

`define SGA_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sga assertion failed");

`endif

// ===== rtl/sga_pkg.sv =====
package sga_pkg;

   localparam int NUM_COLS_DEF   = 4;
   localparam int VALUE_BITS_DEF = 32;
   localparam int PORT_COLS      = 4;
   localparam int IDX_BITS       = $clog2(PORT_COLS);
   localparam int KEY_BITS       = 64;
   localparam int ACC_BITS       = 64;
   localparam int STEP_BITS      = $clog2(ACC_BITS);
   localparam int CNT_BITS       = 32;
   localparam int IN_BITS        = 32;
   localparam int KIND_BITS      = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_UNUSED,
      KIND_COUNT,
      KIND_MIN,
      KIND_MAX,
      KIND_SUM,
      KIND_AVG,
      KIND_FIRST,
      KIND_LAST
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_COL,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]                 key;
      logic [CNT_BITS-1:0]                 rows;
      logic [PORT_COLS-1:0][ACC_BITS-1:0]  acc;
      kind_type [PORT_COLS-1:0]            kind;
      logic                                empty;
   } group_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                   input logic [ACC_BITS-1:0] b);
      logic [ACC_BITS-1:0] s;
      s = a + b;
      if ((a[ACC_BITS-1] == b[ACC_BITS-1]) && (s[ACC_BITS-1] != a[ACC_BITS-1])) begin
         s = a[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

// ===== rtl/sga_if.sv =====
interface sga_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic [sga_pkg::KEY_BITS-1:0]        group_key;
   logic signed [sga_pkg::IN_BITS-1:0]  value_a;
   logic signed [sga_pkg::IN_BITS-1:0]  value_b;
   logic signed [sga_pkg::IN_BITS-1:0]  value_c;
   logic signed [sga_pkg::IN_BITS-1:0]  value_d;
   modport source(output valid, op, group_key, value_a, value_b, value_c, value_d,
                  input ready);
   modport sink(input valid, op, group_key, value_a, value_b, value_c, value_d,
                output ready);
endinterface

interface sga_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sga_pkg::KEY_BITS-1:0]         out_key;
   logic signed [sga_pkg::ACC_BITS-1:0]  agg_a;
   logic signed [sga_pkg::ACC_BITS-1:0]  agg_b;
   logic signed [sga_pkg::ACC_BITS-1:0]  agg_c;
   logic signed [sga_pkg::ACC_BITS-1:0]  agg_d;
   logic                                 group_empty;
   modport source(output valid, out_key, agg_a, agg_b, agg_c, agg_d, group_empty,
                  input ready);
   modport sink(input valid, out_key, agg_a, agg_b, agg_c, agg_d, group_empty,
                output ready);
endinterface

// ===== rtl/sga_front.sv =====
module sga_front #(
   parameter int NUM_COLS   = sga_pkg::NUM_COLS_DEF,
   parameter int VALUE_BITS = sga_pkg::VALUE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   sga_req_if.sink                                     req,
   input  sga_pkg::kind_type [sga_pkg::PORT_COLS-1:0]  kind,
   input  sga_pkg::queue_status_type                   qstat,
   output logic                                        push,
   output sga_pkg::group_type                          grp
);

   localparam int ACTIVE = (NUM_COLS < sga_pkg::PORT_COLS) ? NUM_COLS : sga_pkg::PORT_COLS;
   localparam int AB     = sga_pkg::ACC_BITS;

   logic [sga_pkg::KEY_BITS-1:0]  key_ff, key_in;
   logic                          open_ff, open_in;
   logic [sga_pkg::CNT_BITS-1:0]  rows_ff, rows_in;
   logic [AB-1:0]                 acc_ff [sga_pkg::PORT_COLS];
   logic [AB-1:0]                 acc_in [sga_pkg::PORT_COLS];
   logic [sga_pkg::IN_BITS-1:0]   raw [sga_pkg::PORT_COLS];
   logic [AB-1:0]                 val [sga_pkg::PORT_COLS];
   logic                          accept, split, first;

   assign raw[0] = req.value_a;
   assign raw[1] = req.value_b;
   assign raw[2] = req.value_c;
   assign raw[3] = req.value_d;

   always_comb begin
      for (int c = 0; c < sga_pkg::PORT_COLS; c++) begin
         val[c] = {{(AB-VALUE_BITS){raw[c][VALUE_BITS-1]}}, raw[c][VALUE_BITS-1:0]};
      end
   end

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;
   assign split     = open_ff && (req.group_key != key_ff);
   assign first     = !open_ff || split;
   assign push      = accept && (req.op || split);

   always_comb begin
      grp.key   = open_ff ? key_ff : '0;
      grp.rows  = rows_ff;
      grp.empty = !open_ff;
      grp.kind  = kind;
      for (int c = 0; c < sga_pkg::PORT_COLS; c++) begin
         grp.acc[c] = acc_ff[c];
      end
   end

   always_comb begin
      key_in  = key_ff;
      open_in = open_ff;
      rows_in = rows_ff;
      for (int c = 0; c < sga_pkg::PORT_COLS; c++) begin
         acc_in[c] = acc_ff[c];
      end
      if (accept) begin
         if (req.op) begin
            key_in  = '0;
            open_in = 1'b0;
            rows_in = '0;
            for (int c = 0; c < sga_pkg::PORT_COLS; c++) begin
               acc_in[c] = '0;
            end
         end else begin
            key_in  = req.group_key;
            open_in = 1'b1;
            if (first) begin
               rows_in = sga_pkg::CNT_BITS'(1);
            end else if (rows_ff != '1) begin
               rows_in = rows_ff + sga_pkg::CNT_BITS'(1);
            end
            for (int c = 0; c < ACTIVE; c++) begin
               if (first) begin
                  acc_in[c] = val[c];
               end else begin
                  case (kind[c])
                     sga_pkg::KIND_MIN: begin
                        if ($signed(val[c]) < $signed(acc_ff[c])) acc_in[c] = val[c];
                     end
                     sga_pkg::KIND_MAX: begin
                        if ($signed(val[c]) > $signed(acc_ff[c])) acc_in[c] = val[c];
                     end
                     sga_pkg::KIND_SUM,
                     sga_pkg::KIND_AVG: begin
                        acc_in[c] = sga_pkg::sat_add(acc_ff[c], val[c]);
                     end
                     sga_pkg::KIND_LAST: begin
                        acc_in[c] = val[c];
                     end
                     default: begin
                        acc_in[c] = acc_ff[c];
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         open_ff <= 1'b0;
         rows_ff <= '0;
         for (int c = 0; c < sga_pkg::PORT_COLS; c++) begin
            acc_ff[c] <= '0;
         end
      end else begin
         key_ff  <= key_in;
         open_ff <= open_in;
         rows_ff <= rows_in;
         for (int c = 0; c < sga_pkg::PORT_COLS; c++) begin
            acc_ff[c] <= acc_in[c];
         end
      end
   end

endmodule

// ===== rtl/sga_queue.sv =====
module sga_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sga_pkg::group_type         wr_data,
   input  logic                       pop,
   output sga_pkg::queue_status_type  qstat,
   output sga_pkg::group_type         rd_data
);

   localparam int DEPTH  = sga_pkg::QUEUE_DEPTH;
   localparam int PBITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CBITS  = $clog2(DEPTH + 1);

   sga_pkg::group_type  mem_ff [DEPTH];
   logic [PBITS-1:0]    wr_ff, rd_ff;
   logic [CBITS-1:0]    cnt_ff;
   logic                do_push, do_pop;

   assign qstat.full  = (cnt_ff == CBITS'(DEPTH));
   assign qstat.valid = (cnt_ff != '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && qstat.valid;
   assign rd_data     = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PBITS'(DEPTH - 1)) ? '0 : wr_ff + PBITS'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PBITS'(DEPTH - 1)) ? '0 : rd_ff + PBITS'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CBITS'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CBITS'(1);
         end
      end
   end

endmodule

// ===== rtl/sga_back.sv =====
`include "sorted_group_aggregator_core_defines.svh"

module sga_back #(
   parameter int NUM_COLS = sga_pkg::NUM_COLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid,
   input  sga_pkg::group_type  grp,
   output logic                pop,
   sga_rsp_if.source           rsp
);

   localparam int ACTIVE = (NUM_COLS < sga_pkg::PORT_COLS) ? NUM_COLS : sga_pkg::PORT_COLS;
   localparam int AB     = sga_pkg::ACC_BITS;
   localparam int CB     = sga_pkg::CNT_BITS;
   localparam int IB     = sga_pkg::IDX_BITS;
   localparam int SB     = sga_pkg::STEP_BITS;

   sga_pkg::back_state_type  state_ff, state_in;
   sga_pkg::group_type       ent_ff;
   logic [IB-1:0]            col_ff;
   logic [AB-1:0]            res_ff [sga_pkg::PORT_COLS];
   logic [AB-1:0]            dq_ff;
   logic [CB:0]              rem_ff;
   logic [SB-1:0]            step_ff;
   logic                     neg_ff;

   logic                     col_active, avg_div, last_col;
   logic [AB-1:0]            cur_acc, direct, quot;
   logic [CB:0]              trial;
   logic                     qbit;

   assign cur_acc    = ent_ff.acc[col_ff];
   assign col_active = (int'(col_ff) < ACTIVE) && !ent_ff.empty;
   assign avg_div    = col_active && (ent_ff.kind[col_ff] == sga_pkg::KIND_AVG)
                       && (ent_ff.rows != '0);
   assign last_col   = (col_ff == IB'(sga_pkg::PORT_COLS - 1));

   always_comb begin
      direct = '0;
      if (col_active) begin
         case (ent_ff.kind[col_ff])
            sga_pkg::KIND_COUNT: direct = {{(AB-CB){1'b0}}, ent_ff.rows};
            sga_pkg::KIND_MIN,
            sga_pkg::KIND_MAX,
            sga_pkg::KIND_SUM,
            sga_pkg::KIND_FIRST,
            sga_pkg::KIND_LAST:  direct = cur_acc;
            default:             direct = '0;
         endcase
      end
   end

   assign trial = {rem_ff[CB-1:0], dq_ff[AB-1]};
   assign qbit  = (trial >= {1'b0, ent_ff.rows});
   assign quot  = {dq_ff[AB-2:0], qbit};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sga_pkg::BK_IDLE: begin
            if (valid) state_in = sga_pkg::BK_COL;
         end
         sga_pkg::BK_COL: begin
            if (avg_div)       state_in = sga_pkg::BK_DIV;
            else if (last_col) state_in = sga_pkg::BK_OUT;
         end
         sga_pkg::BK_DIV: begin
            if (step_ff == SB'(AB - 1)) begin
               state_in = last_col ? sga_pkg::BK_OUT : sga_pkg::BK_COL;
            end
         end
         sga_pkg::BK_OUT: begin
            if (rsp.ready) state_in = sga_pkg::BK_IDLE;
         end
         default: state_in = sga_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = (state_ff == sga_pkg::BK_IDLE) && valid;
      rsp.valid = (state_ff == sga_pkg::BK_OUT);
   end

   assign rsp.out_key     = ent_ff.key;
   assign rsp.group_empty = ent_ff.empty;
   assign rsp.agg_a       = res_ff[0];
   assign rsp.agg_b       = res_ff[1];
   assign rsp.agg_c       = res_ff[2];
   assign rsp.agg_d       = res_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sga_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         sga_pkg::BK_IDLE: begin
            if (pop) begin
               ent_ff <= grp;
               col_ff <= '0;
            end
         end
         sga_pkg::BK_COL: begin
            if (avg_div) begin
               dq_ff   <= cur_acc[AB-1] ? (~cur_acc + AB'(1)) : cur_acc;
               neg_ff  <= cur_acc[AB-1];
               rem_ff  <= '0;
               step_ff <= '0;
            end else begin
               res_ff[col_ff] <= direct;
               col_ff         <= col_ff + IB'(1);
            end
         end
         sga_pkg::BK_DIV: begin
            rem_ff  <= qbit ? (trial - {1'b0, ent_ff.rows}) : trial;
            dq_ff   <= quot;
            step_ff <= step_ff + SB'(1);
            if (step_ff == SB'(AB - 1)) begin
               res_ff[col_ff] <= neg_ff ? (~quot + AB'(1)) : quot;
               col_ff         <= col_ff + IB'(1);
            end
         end
         default: begin
         end
      endcase
   end

   `SGA_ASSERT_IMP(a_div_rows_nonzero, clock, reset, state_ff == sga_pkg::BK_DIV, ent_ff.rows != '0)
   `SGA_ASSERT_IMP(a_div_avg_only, clock, reset, state_ff == sga_pkg::BK_DIV, ent_ff.kind[col_ff] == sga_pkg::KIND_AVG)
   `SGA_ASSERT_NXT(a_out_release, clock, reset, rsp.valid && rsp.ready, state_ff == sga_pkg::BK_IDLE)

endmodule

// ===== rtl/sorted_group_aggregator_core.sv =====
// Group-by aggregation over a key-sorted request stream.
// req: valid/ready channel; op 0 is a data row (key plus four values), op 1 flushes
//   the open group. A request is taken every cycle while the group queue has room.
// rsp: valid/ready channel carrying one finished group: key, four aggregates and
//   group_empty (flush with no open group; key and aggregates then zero).
// csr: APB-style port, kind_col0..3 at byte addresses 0, 4, 8, 12; pready tied high.
// A request that closes a group is written into the two-entry group queue at its
//   accepting edge.
// The back end then loads the group, resolves one column at a time, runs a bit-serial
// divider for each average column with a non-zero row count, then holds the response.
// Requests are taken one per cycle while the queue has room; the back end works on one
// group at a time, so a burst of group closes is limited by it once the queue fills.
// A stalled receiver holds rsp and, once the queue fills, drops req.ready.
// Reset (synchronous, active high) clears the open group, kinds and queue.
module sorted_group_aggregator_core #(
   parameter int NUM_COLS   = sga_pkg::NUM_COLS_DEF,
   parameter int VALUE_BITS = sga_pkg::VALUE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   sga_req_if.sink                            req,
   sga_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sga_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sga_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sga_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   sga_pkg::kind_type [sga_pkg::PORT_COLS-1:0]  kind_ff;
   sga_pkg::queue_status_type                   qstat;
   sga_pkg::group_type                          push_grp, pop_grp;
   logic                                        push, pop;
   logic [sga_pkg::IDX_BITS-1:0]                csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[sga_pkg::CSR_ADDR_BITS-1:2];
   assign csr_prdata = {{(sga_pkg::CSR_DATA_BITS-sga_pkg::KIND_BITS){1'b0}}, kind_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < sga_pkg::PORT_COLS; c++) begin
            kind_ff[c] <= sga_pkg::KIND_UNUSED;
         end
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         kind_ff[csr_idx] <= sga_pkg::kind_type'(csr_pwdata[sga_pkg::KIND_BITS-1:0]);
      end
   end

   sga_front #(
      .NUM_COLS   (NUM_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .kind  (kind_ff),
      .qstat (qstat),
      .push  (push),
      .grp   (push_grp)
   );

   sga_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (push_grp),
      .pop     (pop),
      .qstat   (qstat),
      .rd_data (pop_grp)
   );

   sga_back #(
      .NUM_COLS (NUM_COLS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .valid (qstat.valid),
      .grp   (pop_grp),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

// ===== tb/sv/tb.sv =====
module tb;

   typedef struct {
      logic [63:0]        key;
      logic signed [63:0] agg [4];
      logic               empty;
   } group_result_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [sga_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [sga_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [sga_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   sga_req_if req_bus();
   sga_rsp_if rsp_bus();

   sorted_group_aggregator_core u_dut (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   sga_pkg::kind_type  col_kind [4];
   logic [63:0]        open_key;
   bit                 group_live;
   logic [31:0]        group_rows;
   logic signed [63:0] col_acc [4];
   group_result_type   pending_groups [$];

   int src_idle_pct;
   int sink_stall_pct;
   int mismatches;
   int groups_seen;
   int empties_seen;
   int rows_sent;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= (reset == 1'b0) && ($urandom_range(99) >= sink_stall_pct);
   end

   function automatic logic signed [63:0] col_value(int c);
      case (col_kind[c])
         sga_pkg::KIND_COUNT: return $signed({32'b0, group_rows});
         sga_pkg::KIND_MIN, sga_pkg::KIND_MAX, sga_pkg::KIND_SUM,
         sga_pkg::KIND_FIRST, sga_pkg::KIND_LAST: return col_acc[c];
         sga_pkg::KIND_AVG: begin
            if (group_rows == 0) return 0;
            return col_acc[c] / $signed({32'b0, group_rows});
         end
         default: return 0;
      endcase
   endfunction

   function automatic logic signed [63:0] add_saturated(logic signed [63:0] a,
                                                        logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   function automatic void push_group(bit empty);
      group_result_type g;
      g.key   = empty ? 64'd0 : open_key;
      for (int c = 0; c < 4; c++) g.agg[c] = empty ? 64'sd0 : col_value(c);
      g.empty = empty;
      pending_groups.insert(pending_groups.size(), g);
   endfunction

   function automatic void close_group();
      group_live = 0;
      group_rows = 0;
      for (int c = 0; c < 4; c++) col_acc[c] = 0;
   endfunction

   function automatic void take_row(logic [63:0] key, logic signed [31:0] v [4]);
      logic signed [63:0] x;
      bit first;
      first = !group_live;
      open_key = key;
      group_live = 1;
      for (int c = 0; c < 4; c++) begin
         x = v[c];
         if (first) col_acc[c] = x;
         else case (col_kind[c])
            sga_pkg::KIND_MIN: if (x < col_acc[c]) col_acc[c] = x;
            sga_pkg::KIND_MAX: if (x > col_acc[c]) col_acc[c] = x;
            sga_pkg::KIND_SUM, sga_pkg::KIND_AVG: col_acc[c] = add_saturated(col_acc[c], x);
            sga_pkg::KIND_LAST: col_acc[c] = x;
            default: ;
         endcase
      end
      if (group_rows != 32'hFFFF_FFFF) group_rows++;
   endfunction

   function automatic void predict_request(bit op, logic [63:0] key,
                                           logic signed [31:0] v [4]);
      if (op) begin
         push_group(!group_live);
         close_group();
         open_key = 0;
      end else begin
         if (group_live && key != open_key) begin
            push_group(0);
            close_group();
         end
         take_row(key, v);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         group_result_type g;
         logic signed [63:0] got [4];
         got = '{rsp_bus.agg_a, rsp_bus.agg_b, rsp_bus.agg_c, rsp_bus.agg_d};
         if (pending_groups.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected group key %h", rsp_bus.out_key);
         end else begin
            g = pending_groups.pop_front();
            groups_seen++;
            if (g.empty) empties_seen++;
            if (g.key !== rsp_bus.out_key || g.empty !== rsp_bus.group_empty ||
                g.agg[0] !== got[0] || g.agg[1] !== got[1] ||
                g.agg[2] !== got[2] || g.agg[3] !== got[3]) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp key %h agg %0d %0d %0d %0d empty %0b",
                           g.key, g.agg[0], g.agg[1], g.agg[2], g.agg[3], g.empty);
                  $display("         got key %h agg %0d %0d %0d %0d empty %0b",
                           rsp_bus.out_key, got[0], got[1], got[2], got[3],
                           rsp_bus.group_empty);
               end
            end
         end
      end
   end

   task automatic send_request(bit op, logic [63:0] key, logic signed [31:0] v [4]);
      int gap;
      gap = 0;
      while ($urandom_range(99) < src_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.group_key <= key;
      req_bus.value_a   <= v[0];
      req_bus.value_b   <= v[1];
      req_bus.value_c   <= v[2];
      req_bus.value_d   <= v[3];
      do @(posedge clock); while (!req_bus.ready);
      predict_request(op, key, v);
      rows_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [2:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= sga_pkg::CSR_ADDR_BITS'(idx * 4);
      csr_pwdata  <= {29'b0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      col_kind[idx] = sga_pkg::kind_type'(val);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_kinds(sga_pkg::kind_type k0, sga_pkg::kind_type k1,
                            sga_pkg::kind_type k2, sga_pkg::kind_type k3);
      csr_write(0, k0);
      csr_write(1, k1);
      csr_write(2, k2);
      csr_write(3, k3);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 0;
         3: return -1;
         4: return $signed(32'($urandom_range(20))) - 10;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic send_row(logic [63:0] key);
      logic signed [31:0] v [4];
      for (int c = 0; c < 4; c++) v[c] = pick_value();
      send_request(1'b0, key, v);
   endtask

   task automatic send_end();
      logic signed [31:0] v [4];
      for (int c = 0; c < 4; c++) v[c] = $signed($urandom);
      send_request(1'b1, {$urandom, $urandom}, v);
   endtask

   task automatic test_basic_kinds();
      logic signed [31:0] v [4];
      set_kinds(sga_pkg::KIND_COUNT, sga_pkg::KIND_MIN, sga_pkg::KIND_MAX, sga_pkg::KIND_SUM);
      send_end();
      v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
      send_request(1'b0, 64'd0, v);
      v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
      send_request(1'b0, 64'd0, v);
      v = '{-1, 0, 1, -1};
      send_request(1'b0, 64'd0, v);
      send_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, v);
      v = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
      send_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, v);
      send_request(1'b0, 64'h5555_AAAA_5555_AAAA, v);
      send_end();
      send_end();
      drain();
   endtask

   task automatic test_avg_first_last();
      logic signed [31:0] v [4];
      set_kinds(sga_pkg::KIND_AVG, sga_pkg::KIND_FIRST, sga_pkg::KIND_LAST,
                sga_pkg::KIND_UNUSED);
      v = '{-7, 5, 6, 9};
      send_request(1'b0, 64'hAAAA_5555_AAAA_5555, v);
      v = '{-1, 3, 2, 1};
      send_request(1'b0, 64'hAAAA_5555_AAAA_5555, v);
      v = '{32'sh8000_0000, 32'sh7FFF_FFFF, -5, 4};
      send_request(1'b0, 64'hAAAA_5555_AAAA_5555, v);
      v = '{7, 1, 1, 1};
      send_request(1'b0, 64'h1, v);
      send_request(1'b0, 64'h1, v);
      send_end();
      drain();
   endtask

   task automatic test_kind_change_in_group();
      set_kinds(sga_pkg::KIND_SUM, sga_pkg::KIND_MIN, sga_pkg::KIND_LAST, sga_pkg::KIND_COUNT);
      send_row(64'h77);
      send_row(64'h77);
      drain();
      set_kinds(sga_pkg::KIND_MAX, sga_pkg::KIND_AVG, sga_pkg::KIND_FIRST, sga_pkg::KIND_SUM);
      send_row(64'h77);
      send_row(64'h77);
      send_end();
      drain();
   endtask

   task automatic test_random_phase(int src_pct, int sink_pct, int n_items);
      logic [63:0] key;
      int sent;
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      key  = {$urandom, $urandom};
      sent = 0;
      while (sent < n_items) begin
         int len;
         len = $urandom_range(6, 1);
         if ($urandom_range(15) == 0) len = $urandom_range(20, 7);
         repeat (len) begin
            send_row(key);
            sent++;
         end
         if ($urandom_range(9) == 0) key = {$urandom, $urandom};
         else key = key + 64'($urandom_range(3, 1));
         if ($urandom_range(7) == 0) begin
            send_end();
            sent++;
            if ($urandom_range(3) == 0) begin
               send_end();
               sent++;
            end
         end
         if ($urandom_range(99) == 0) begin
            drain();
            for (int c = 0; c < 4; c++) csr_write(c, 3'($urandom_range(7)));
         end
      end
      send_end();
      drain();
   endtask

   task automatic test_random();
      int pcts [4][2];
      pcts = '{'{0, 0}, '{64, 0}, '{0, 64}, '{29, 29}};
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: set_kinds(sga_pkg::KIND_UNUSED, sga_pkg::KIND_UNUSED,
                         sga_pkg::KIND_UNUSED, sga_pkg::KIND_UNUSED);
            1: set_kinds(sga_pkg::KIND_LAST, sga_pkg::KIND_LAST,
                         sga_pkg::KIND_LAST, sga_pkg::KIND_LAST);
            default: for (int c = 0; c < 4; c++) csr_write(c, 3'($urandom_range(7)));
         endcase
         test_random_phase(pcts[p][0], pcts[p][1], 330);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.op     <= 1'b0;
      req_bus.group_key <= '0;
      req_bus.value_a <= '0;
      req_bus.value_b <= '0;
      req_bus.value_c <= '0;
      req_bus.value_d <= '0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      mismatches     = 0;
      groups_seen    = 0;
      empties_seen   = 0;
      rows_sent      = 0;
      for (int c = 0; c < 4; c++) col_kind[c] = sga_pkg::KIND_UNUSED;
      open_key = 0;
      close_group();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_kinds();
      test_avg_first_last();
      test_kind_change_in_group();
      test_random();
      drain();
      $display("covered %0d requests, %0d groups (%0d empty flushes), four idle phases",
               rows_sent, groups_seen, empties_seen);
      $display("mismatches: %0d, groups left over: %0d", mismatches, pending_groups.size());
      if (mismatches == 0 && pending_groups.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
